// File: sv/quintic_ptp_trajectory_defines.svh
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUINTIC_PTP_TRAJECTORY_DEFINES_SVH
`define QUINTIC_PTP_TRAJECTORY_DEFINES_SVH

// Same-cycle implication
`define QPTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QPTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/qptp_pkg.sv
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory: package
// Transfer types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package qptp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_VEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_ACC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_VEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ACC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP   = 3'd4;

  // datapath widths
  localparam int unsigned MUL_W  = 34;  // signed multiplier operands
  localparam int unsigned PROD_W = 68;
  localparam int unsigned DIV_W  = 60;  // dividend / quotient
  localparam int unsigned DVS_W  = 35;  // divisor
  localparam int unsigned RAD_W  = 68;  // square root radicand
  localparam int unsigned ROOT_W = 34;

  // round(10/sqrt(3) * 2^24)
  localparam logic [26:0] ACC_GAIN = 27'd96863302;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_k;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] end_k;
    logic        [31:0] min_time;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_k;
    logic        [31:0] stamp;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/quintic_ptp_trajectory.sv
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory planner
// Load: sum of squares, 34-step root, then per part up to two 60-step divisions
//   and one 34-step root. Step: up to one 60-step division, four products and
//   four interpolation products.
// One item at a time; the next item is taken once the result is registered.
// Reset is asynchronous, active low; it clears poses, time and blend state and
// loads the limit registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_ptp_trajectory (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  qptp_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output qptp_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qptp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);
  import qptp_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LD_SQ    = 5'd1;
  localparam logic [4:0] S_LD_ACC   = 5'd2;
  localparam logic [4:0] S_LD_LEN   = 5'd3;
  localparam logic [4:0] S_SQRT     = 5'd4;
  localparam logic [4:0] S_DIV      = 5'd5;
  localparam logic [4:0] S_PT_BEGIN = 5'd6;
  localparam logic [4:0] S_PT_TV    = 5'd7;
  localparam logic [4:0] S_PT_AMUL  = 5'd8;
  localparam logic [4:0] S_PT_ADIV  = 5'd9;
  localparam logic [4:0] S_PT_ASQ   = 5'd10;
  localparam logic [4:0] S_PT_TA    = 5'd11;
  localparam logic [4:0] S_PT_END   = 5'd12;
  localparam logic [4:0] S_LD_FIN   = 5'd13;
  localparam logic [4:0] S_ST_BEGIN = 5'd14;
  localparam logic [4:0] S_ST_U     = 5'd15;
  localparam logic [4:0] S_ST_M1    = 5'd16;
  localparam logic [4:0] S_ST_M2    = 5'd17;
  localparam logic [4:0] S_ST_M3    = 5'd18;
  localparam logic [4:0] S_ST_M4    = 5'd19;
  localparam logic [4:0] S_ST_CHK   = 5'd20;
  localparam logic [4:0] S_ST_IP    = 5'd21;
  localparam logic [4:0] S_ST_IA    = 5'd22;
  localparam logic [4:0] S_ST_FIN   = 5'd23;
  localparam logic [4:0] S_EMIT     = 5'd24;

  localparam logic [5:0] DIV_LAST  = 6'(DIV_W - 1);
  localparam logic [5:0] ROOT_LAST = 6'(ROOT_W - 1);

  localparam logic signed [MUL_W-1:0] C0 = 34'sd167772160;   // 10 in Q8.24
  localparam logic signed [MUL_W-1:0] C1 = -34'sd251658240;  // -15 in Q8.24
  localparam logic [24:0]             BLEND_ONE = 25'h100_0000;
  localparam logic signed [43:0]      S_ONE = 44'sd16777216;
  localparam logic signed [34:0]      SNAP_ONE = 35'sd16777216;

  // control
  logic [4:0]  state_q, ret_q;
  logic [5:0]  cnt_q;
  logic [1:0]  idx_q;
  logic        part_q, skip_q;
  logic        out_valid_q;

  // configuration
  logic [31:0] lin_vel_q, lin_acc_q, rot_vel_q, rot_acc_q, tstep_q;

  // move state
  logic signed [31:0] start_q [4];
  logic signed [31:0] goal_q  [4];
  logic [31:0] total_q, elapsed_q, blend_q;
  logic        coef_q;

  // datapath
  logic [31:0] mt_q, tv_q, ta_q, tmax_q;
  logic [65:0] acc_q;
  logic [32:0] len_q, l_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q, drem_q;
  logic [RAD_W-1:0]  rad_q;
  logic [35:0]       srem_q;
  logic [ROOT_W-1:0] root_q;
  logic [24:0] u_q, u3_q, s_q;
  logic        res_ok_q;
  logic [31:0] res_pos_q [4];
  logic [31:0] res_stamp_q;
  out_item_t   out_q;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [43:0] blend_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [43:0] q;
    q = p[PROD_W-1:24];
    if (p[PROD_W-1] && (p[23:0] != '0)) q = q + 44'sd1;
    return q;
  endfunction

  // per-axis difference and magnitude
  logic signed [32:0] diff_s, diff_n, rdiff_s, rdiff_n;
  logic [31:0] diff_mag, rlen;
  assign diff_s   = {goal_q[idx_q][31], goal_q[idx_q]} - {start_q[idx_q][31], start_q[idx_q]};
  assign diff_n   = -diff_s;
  assign diff_mag = diff_s[32] ? diff_n[31:0] : diff_s[31:0];
  assign rdiff_s  = {goal_q[3][31], goal_q[3]} - {start_q[3][31], start_q[3]};
  assign rdiff_n  = -rdiff_s;
  assign rlen     = rdiff_s[32] ? rdiff_n[31:0] : rdiff_s[31:0];

  // current part: path or rotation
  logic [32:0] cur_len;
  logic [31:0] cur_vel, cur_acc;
  logic [36:0] len15;
  assign cur_len = part_q ? {1'b0, rlen} : len_q;
  assign cur_vel = part_q ? rot_vel_q : lin_vel_q;
  assign cur_acc = part_q ? rot_acc_q : lin_acc_q;
  assign len15   = {cur_len, 4'b0} - {4'b0, cur_len};

  // blend terms
  logic [27:0]              u6;
  logic signed [MUL_W-1:0]  inner_s, mid_s;
  logic signed [43:0]       t_blend;
  logic [24:0]              s_cl;
  logic signed [34:0]       snap_v;
  logic                     s_over, snap;
  assign u6      = {1'b0, u_q, 2'b0} + {2'b0, u_q, 1'b0};
  assign inner_s = coef_q ? C1 + $signed({6'b0, u6}) : '0;
  assign t_blend = blend_trunc(prod_q);
  assign mid_s   = (coef_q ? C0 : '0) + t_blend[MUL_W-1:0];
  assign s_over  = t_blend > S_ONE;
  assign s_cl    = t_blend[43] ? '0 : t_blend[24:0];
  assign snap_v  = $signed({9'b0, s_cl, 1'b0}) - $signed({3'b0, blend_q});
  assign snap    = snap_v > SNAP_ONE;

  // time selection for one part
  logic [31:0] tvta, t_req, t_part, tv_sat, ta_sat;
  assign tv_sat = (|dvd_q[DIV_W-1:32]) ? TIME_MAX : dvd_q[31:0];
  assign ta_sat = (|root_q[ROOT_W-1:32]) ? TIME_MAX : root_q[31:0];
  assign tvta   = (tv_q > ta_q) ? tv_q : ta_q;
  assign t_req  = (mt_q > tvta) ? mt_q : tvta;
  assign t_part = skip_q ? '0 : t_req;

  logic [32:0] el_sum;
  logic [31:0] el_sat;
  assign el_sum = {1'b0, elapsed_q} + {1'b0, tstep_q};
  assign el_sat = el_sum[32] ? TIME_MAX : el_sum[31:0];

  logic [65:0] acc_next;
  assign acc_next = acc_q + {2'b0, prod_q[63:0]};

  // divider step: one quotient bit per cycle
  logic [DVS_W:0] d_trial, d_sub;
  logic           d_ge;
  assign d_trial = {drem_q, dvd_q[DIV_W-1]};
  assign d_sub   = d_trial - {1'b0, dvs_q};
  assign d_ge    = d_trial >= {1'b0, dvs_q};

  // square root step: one root bit per cycle
  logic [37:0] s_rem, s_try, s_sub;
  logic        s_ge;
  assign s_rem = {srem_q, rad_q[RAD_W-1 -: 2]};
  assign s_try = {2'b0, root_q, 2'b01};
  assign s_sub = s_rem - s_try;
  assign s_ge  = s_rem >= s_try;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  always_comb begin
    case (state_q)
      S_LD_SQ: begin
        mul_a = {2'b0, diff_mag};
        mul_b = {2'b0, diff_mag};
      end
      S_PT_AMUL: begin
        mul_a = {7'b0, ACC_GAIN};
        mul_b = {1'b0, l_q};
      end
      S_ST_M1: begin
        mul_a = {9'b0, u_q};
        mul_b = {9'b0, u_q};
      end
      S_ST_M2: begin
        mul_a = {9'b0, prod_q[48:24]};
        mul_b = {9'b0, u_q};
      end
      S_ST_M3: begin
        mul_a = inner_s;
        mul_b = {9'b0, u_q};
      end
      S_ST_M4: begin
        mul_a = mid_s;
        mul_b = {9'b0, u3_q};
      end
      S_ST_IP: begin
        mul_a = {9'b0, s_q};
        mul_b = {diff_s[32], diff_s};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic accept, emit_fire, step_done;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign emit_fire   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign step_done   = (dvd_q > 60'd16777216);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------- control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      part_q      <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      lin_vel_q   <= 32'd65536;
      lin_acc_q   <= 32'd65536;
      rot_vel_q   <= 32'd65536;
      rot_acc_q   <= 32'd65536;
      tstep_q     <= 32'd655;
      for (int i = 0; i < 4; i++) begin
        start_q[i] <= '0;
        goal_q[i]  <= '0;
      end
      total_q   <= '0;
      elapsed_q <= '0;
      blend_q   <= '0;
      coef_q    <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LIN_VEL: lin_vel_q <= cfg_data_i;
          REG_LIN_ACC: lin_acc_q <= cfg_data_i;
          REG_ROT_VEL: rot_vel_q <= cfg_data_i;
          REG_ROT_ACC: rot_acc_q <= cfg_data_i;
          REG_TSTEP:   tstep_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // result register
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!in_data_i.kind) begin
              start_q[0] <= in_data_i.start_x;
              start_q[1] <= in_data_i.start_y;
              start_q[2] <= in_data_i.start_z;
              start_q[3] <= in_data_i.start_k;
              goal_q[0]  <= in_data_i.end_x;
              goal_q[1]  <= in_data_i.end_y;
              goal_q[2]  <= in_data_i.end_z;
              goal_q[3]  <= in_data_i.end_k;
              idx_q      <= '0;
              part_q     <= 1'b0;
              state_q    <= S_LD_SQ;
            end else begin
              state_q <= S_ST_BEGIN;
            end
          end
        end
        S_LD_SQ: state_q <= S_LD_ACC;
        S_LD_ACC: begin
          if (idx_q == 2'd2) begin
            ret_q   <= S_LD_LEN;
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_LD_SQ;
          end
        end
        S_SQRT: begin
          if (cnt_q == ROOT_LAST) state_q <= ret_q;
          else cnt_q <= cnt_q + 6'd1;
        end
        S_DIV: begin
          if (cnt_q == DIV_LAST) state_q <= ret_q;
          else cnt_q <= cnt_q + 6'd1;
        end
        S_LD_LEN: state_q <= S_PT_BEGIN;
        S_PT_BEGIN: begin
          if (cur_len == '0) begin
            skip_q  <= 1'b1;
            state_q <= S_PT_END;
          end else begin
            skip_q <= 1'b0;
            if (cur_vel == '0) begin
              state_q <= S_PT_AMUL;
            end else begin
              ret_q   <= S_PT_TV;
              cnt_q   <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_PT_TV: state_q <= S_PT_AMUL;
        S_PT_AMUL: state_q <= (cur_acc == '0) ? S_PT_END : S_PT_ADIV;
        S_PT_ADIV: begin
          ret_q   <= S_PT_ASQ;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_PT_ASQ: begin
          ret_q   <= S_PT_TA;
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_PT_TA: state_q <= S_PT_END;
        S_PT_END: begin
          if (part_q) begin
            state_q <= S_LD_FIN;
          end else begin
            part_q  <= 1'b1;
            state_q <= S_PT_BEGIN;
          end
        end
        S_LD_FIN: begin
          total_q   <= tmax_q;
          elapsed_q <= '0;
          blend_q   <= '0;
          coef_q    <= |tmax_q;
          state_q   <= S_EMIT;
        end
        S_ST_BEGIN: begin
          if (total_q == '0) begin
            state_q <= S_ST_M1;
          end else begin
            ret_q   <= S_ST_U;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_ST_U:  state_q <= step_done ? S_EMIT : S_ST_M1;
        S_ST_M1: state_q <= S_ST_M2;
        S_ST_M2: state_q <= S_ST_M3;
        S_ST_M3: state_q <= S_ST_M4;
        S_ST_M4: state_q <= S_ST_CHK;
        S_ST_CHK: begin
          if (s_over) begin
            state_q <= S_EMIT;
          end else begin
            if (snap) elapsed_q <= total_q;
            idx_q   <= '0;
            state_q <= S_ST_IP;
          end
        end
        S_ST_IP: state_q <= S_ST_IA;
        S_ST_IA: begin
          if (idx_q == 2'd3) begin
            state_q <= S_ST_FIN;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_ST_IP;
          end
        end
        S_ST_FIN: begin
          elapsed_q <= el_sat;
          blend_q   <= {7'b0, s_q};
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mt_q   <= in_data_i.min_time;
        acc_q  <= '0;
        tmax_q <= '0;
      end
      S_LD_SQ: prod_q <= mul_p;
      S_LD_ACC: begin
        acc_q  <= acc_next;
        rad_q  <= {2'b0, acc_next};
        srem_q <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        srem_q <= s_ge ? s_sub[35:0] : s_rem[35:0];
        root_q <= {root_q[ROOT_W-2:0], s_ge};
        rad_q  <= {rad_q[RAD_W-3:0], 2'b0};
      end
      S_DIV: begin
        drem_q <= d_ge ? d_sub[DVS_W-1:0] : d_trial[DVS_W-1:0];
        dvd_q  <= {dvd_q[DIV_W-2:0], d_ge};
      end
      S_LD_LEN: len_q <= root_q[32:0];
      S_PT_BEGIN: begin
        l_q  <= cur_len;
        tv_q <= (cur_vel == '0) ? TIME_MAX : '0;
        ta_q <= '0;
        dvd_q  <= {7'b0, len15, 16'b0};
        dvs_q  <= {cur_vel, 3'b0};
        drem_q <= '0;
      end
      S_PT_TV: tv_q <= tv_sat;
      S_PT_AMUL: begin
        if (cur_acc == '0) ta_q <= TIME_MAX;
        prod_q <= mul_p;
      end
      S_PT_ADIV: begin
        dvd_q  <= prod_q[DIV_W-1:0];
        dvs_q  <= {3'b0, cur_acc};
        drem_q <= '0;
      end
      S_PT_ASQ: begin
        rad_q  <= {dvd_q, 8'b0};
        srem_q <= '0;
        root_q <= '0;
      end
      S_PT_TA: ta_q <= ta_sat;
      S_PT_END: tmax_q <= (t_part > tmax_q) ? t_part : tmax_q;
      S_LD_FIN: begin
        res_ok_q    <= |tmax_q;
        res_stamp_q <= '0;
        for (int i = 0; i < 4; i++) res_pos_q[i] <= '0;
      end
      S_ST_BEGIN: begin
        u_q    <= '0;
        dvd_q  <= {4'b0, elapsed_q, 24'b0};
        dvs_q  <= {3'b0, total_q};
        drem_q <= '0;
      end
      S_ST_U: begin
        u_q         <= dvd_q[24:0];
        res_ok_q    <= 1'b0;
        res_stamp_q <= '0;
        for (int i = 0; i < 4; i++) res_pos_q[i] <= '0;
      end
      S_ST_M1: prod_q <= mul_p;
      S_ST_M2: prod_q <= mul_p;
      S_ST_M3: begin
        u3_q   <= prod_q[48:24];
        prod_q <= mul_p;
      end
      S_ST_M4: prod_q <= mul_p;
      S_ST_CHK: s_q <= snap ? BLEND_ONE : s_cl;
      S_ST_IP: prod_q <= mul_p;
      S_ST_IA: res_pos_q[idx_q] <= start_q[idx_q] + prod_q[55:24];
      S_ST_FIN: begin
        res_ok_q    <= 1'b1;
        res_stamp_q <= elapsed_q;
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_q.ok    <= res_ok_q;
          out_q.out_x <= res_pos_q[0];
          out_q.out_y <= res_pos_q[1];
          out_q.out_z <= res_pos_q[2];
          out_q.out_k <= res_pos_q[3];
          out_q.stamp <= res_stamp_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/qptp_checker.sv
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory: port checker
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quintic_ptp_trajectory_defines.svh"

module qptp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input qptp_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);

  // a waiting result holds
  `QPTP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // busy straight after an input transfer
  `QPTP_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready right after input transfer")

  // no result in the cycle after an input transfer, if none was waiting
  `QPTP_ASSERT_NEXT(a_no_instant, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o, "result too early")

  // rejected loads and finished steps carry zero fields
  `QPTP_ASSERT_IMP(a_zero_fields, out_valid_o && !out_data_o.ok, out_data_o.out_x == 0 && out_data_o.out_y == 0 && out_data_o.out_z == 0 && out_data_o.out_k == 0 && out_data_o.stamp == 0, "non-zero fields with ok low")

  // register writes are always taken
  `QPTP_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_o, "configuration port not ready")

endmodule

bind quintic_ptp_trajectory qptp_checker u_qptp_checker (.*);

`default_nettype wire

// File: sim/tb_quintic_ptp_trajectory.sv
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory planner: testbench
// Loads moves and requests via points through the valid/ready channels,
// predicts every result from its own fixed-point model of the planner and
// checks each transfer field by field, under random idling on both sides,
// with one long output hold-off and several limit register settings.
// ----------------------------------------------------------------------------
module tb_quintic_ptp_trajectory;
  timeunit 1ns;
  timeprecision 1ps;
  import qptp_pkg::*;

  localparam longint BLEND_ONE = 64'sd1 << 24;
  localparam logic [63:0] T_SAT = 64'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  quintic_ptp_trajectory u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // planner mirror
  logic [31:0] lim_lin_vel = 32'd65536, lim_lin_acc = 32'd65536;
  logic [31:0] lim_rot_vel = 32'd65536, lim_rot_acc = 32'd65536;
  logic [31:0] step_len = 32'd655;
  longint start_p[4], goal_p[4];
  logic [31:0] move_time = '0, elapsed_t = '0, blend_last = '0;
  bit quintic_on;

  out_item_t via_q[$];
  int unsigned fails = 0;
  bit steady = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic logic [63:0] root128(logic [127:0] v);
    logic [63:0] res, rem, trial;
    res = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 64'(v[2*i +: 2]);
      trial = (res << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        res = (res << 1) | 64'd1;
      end else begin
        res = res << 1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] sat_t(logic [63:0] t);
    return (t > T_SAT) ? T_SAT : t;
  endfunction

  // slower of the velocity and acceleration bound times
  function automatic logic [63:0] part_time(logic [63:0] len, logic [31:0] vel,
                                            logic [31:0] acc);
    logic [63:0] tv, ta, q;
    tv = (vel == 0) ? T_SAT : sat_t(((64'd15 * len) << 16) / (64'd8 * vel));
    if (acc == 0) begin
      ta = T_SAT;
    end else begin
      q = (64'(ACC_GAIN) * len) / 64'(acc);
      ta = sat_t(root128({64'd0, q} << 8));
    end
    return (tv > ta) ? tv : ta;
  endfunction

  function automatic out_item_t plan_move(in_item_t it);
    out_item_t r;
    logic [127:0] sq;
    logic [63:0] d, len, rlen, pt, rt, tt;
    r = '0;
    start_p = '{longint'(it.start_x), longint'(it.start_y),
                longint'(it.start_z), longint'(it.start_k)};
    goal_p = '{longint'(it.end_x), longint'(it.end_y),
               longint'(it.end_z), longint'(it.end_k)};
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d = (goal_p[i] < start_p[i]) ? 64'(start_p[i] - goal_p[i])
                                   : 64'(goal_p[i] - start_p[i]);
      sq = sq + 128'(d) * 128'(d);
    end
    len = root128(sq);
    rlen = (goal_p[3] < start_p[3]) ? 64'(start_p[3] - goal_p[3])
                                    : 64'(goal_p[3] - start_p[3]);
    pt = 0;
    rt = 0;
    if (len != 0) begin
      pt = part_time(len, lim_lin_vel, lim_lin_acc);
      if (64'(it.min_time) > pt) pt = 64'(it.min_time);
    end
    if (rlen != 0) begin
      rt = part_time(rlen, lim_rot_vel, lim_rot_acc);
      if (64'(it.min_time) > rt) rt = 64'(it.min_time);
    end
    tt = (pt > rt) ? pt : rt;
    move_time = tt[31:0];
    elapsed_t = '0;
    blend_last = '0;
    quintic_on = (tt != 0);
    r.ok = quintic_on;
    return r;
  endfunction

  function automatic logic [31:0] lerp(longint a, longint b, longint s);
    longint prod, q;
    prod = s * (b - a);
    q = prod / BLEND_ONE;
    if (prod < 0 && (prod % BLEND_ONE) != 0) q = q - 1;
    return 32'(a + q);
  endfunction

  function automatic out_item_t next_via();
    out_item_t r;
    longint u, u2, u3, inner, mid, s, c0, c1, c2;
    logic [63:0] nt;
    r = '0;
    c0 = quintic_on ? 10 * BLEND_ONE : 0;
    c1 = quintic_on ? -15 * BLEND_ONE : 0;
    c2 = quintic_on ? 6 * BLEND_ONE : 0;
    u = (move_time == 0) ? 0 : longint'({elapsed_t, 24'd0} / 64'(move_time));
    if (u > BLEND_ONE) return r;
    u2 = u * u / BLEND_ONE;
    u3 = u2 * u / BLEND_ONE;
    inner = c1 + c2 * u / BLEND_ONE;
    mid = c0 + inner * u / BLEND_ONE;
    s = mid * u3 / BLEND_ONE;
    if (s > BLEND_ONE) return r;
    if (s < 0) s = 0;
    // close to the goal: snap to it
    if (2 * s - longint'(blend_last) > BLEND_ONE) begin
      s = BLEND_ONE;
      elapsed_t = move_time;
    end
    r.ok = 1'b1;
    r.out_x = lerp(start_p[0], goal_p[0], s);
    r.out_y = lerp(start_p[1], goal_p[1], s);
    r.out_z = lerp(start_p[2], goal_p[2], s);
    r.out_k = lerp(start_p[3], goal_p[3], s);
    r.stamp = elapsed_t;
    nt = 64'(elapsed_t) + 64'(step_len);
    elapsed_t = 32'(sat_t(nt));
    blend_last = s[31:0];
    return r;
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    via_q.push_back(it.kind ? next_via() : plan_move(it));
  endtask

  task automatic drain();
    if (in_valid_i) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (via_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LIN_VEL: lim_lin_vel = val;
      REG_LIN_ACC: lim_lin_acc = val;
      REG_ROT_VEL: lim_rot_vel = val;
      REG_ROT_ACC: lim_rot_acc = val;
      REG_TSTEP:   step_len = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] lv, logic [31:0] la, logic [31:0] rv,
                            logic [31:0] ra, logic [31:0] ts);
    drain();
    write_reg(REG_LIN_VEL, lv);
    write_reg(REG_LIN_ACC, la);
    write_reg(REG_ROT_VEL, rv);
    write_reg(REG_ROT_ACC, ra);
    write_reg(REG_TSTEP, ts);
  endtask

  function automatic in_item_t load_item(logic [31:0] sx, logic [31:0] sy,
      logic [31:0] sz, logic [31:0] sk, logic [31:0] ex, logic [31:0] ey,
      logic [31:0] ez, logic [31:0] ek, logic [31:0] mt);
    in_item_t it;
    it = '{1'b0, sx, sy, sz, sk, ex, ey, ez, ek, mt};
    return it;
  endfunction

  function automatic in_item_t step_item();
    in_item_t it;
    // unused fields carry noise
    it = '{1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    return it;
  endfunction

  task automatic send_steps(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(step_item());
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int unsigned spread);
    logic [31:0] d;
    d = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(0, spread));
    return $urandom_range(0, 1) ? base + d : base - d;
  endfunction

  // random move, mostly with modest travel and sometimes with noise fields, followed by a run of via points
  task automatic random_move();
    in_item_t it;
    logic [31:0] mt;
    it = step_item();
    if ($urandom_range(0, 9) == 0) begin
      it.kind = 1'b0;
    end else begin
      it = load_item($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 21)),
                     $urandom, 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
                     $urandom, '0, '0, '0, '0, '0);
      it.end_x = near(it.start_x, 1 << 17);
      it.end_y = near(it.start_y, 1 << 17);
      it.end_z = near(it.start_z, 1 << 17);
      it.end_k = near(it.start_k, 1 << 17);
      mt = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 1 << 18)) : 32'd0;
      it.min_time = mt;
    end
    send_item(it);
    send_steps($urandom_range(1, 40));
  endtask

  task automatic mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    fails++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (via_q.size() == 0) begin
        mismatch("unexpected transfer", 32'(out_data_o.ok), '0);
      end else begin
        w = via_q.pop_front();
        if (out_data_o.ok !== w.ok) mismatch("ok", 32'(out_data_o.ok), 32'(w.ok));
        if (out_data_o.out_x !== w.out_x) mismatch("out_x", out_data_o.out_x, w.out_x);
        if (out_data_o.out_y !== w.out_y) mismatch("out_y", out_data_o.out_y, w.out_y);
        if (out_data_o.out_z !== w.out_z) mismatch("out_z", out_data_o.out_z, w.out_z);
        if (out_data_o.out_k !== w.out_k) mismatch("out_k", out_data_o.out_k, w.out_k);
        if (out_data_o.stamp !== w.stamp) mismatch("stamp", out_data_o.stamp, w.stamp);
      end
    end
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_cycles == 0);
    end
  end

  task automatic test_reset_state();
    send_steps(2);
    send_item(load_item('0, '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    send_steps(2);
  endtask

  task automatic test_directed_moves();
    send_item(load_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0));
    send_steps(2);
    // rotation only, requested time larger
    send_item(load_item(32'h1000, 32'h2000, 32'h3000, '0,
                        32'h1000, 32'h2000, 32'h3000, 32'h0001_0000, 32'h0004_0000));
    send_steps(3);
    // short move, stepped through part of its course
    send_item(load_item('0, '0, '0, '0, 32'h100, 32'hFFFF_FF00, '0, '0, '0));
    send_steps(8);
  endtask

  task automatic test_limit_extremes();
    set_limits(32'd1, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_item(load_item('0, '0, '0, '0, 32'h10000, '0, '0, 32'hFFFF_0000, '0));
    send_steps(2);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_item(load_item('0, '0, '0, '0, 32'h10, 32'h10, '0, 32'h1, '0));
    send_steps(3);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_cycles = 1500;
    random_move();
    steady = 1'b0;
  endtask

  task automatic test_random(int unsigned n_moves);
    for (int unsigned i = 0; i < n_moves; i++) begin
      steady = ($urandom_range(0, 5) == 0);
      random_move();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_moves();
    test_limit_extremes();
    set_limits(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd655);
    test_backpressure();
    for (int p = 0; p < 4; p++) begin
      set_limits($urandom_range(1 << 14, 1 << 21), $urandom_range(1 << 14, 1 << 21),
                 $urandom_range(1 << 14, 1 << 21), $urandom_range(1 << 14, 1 << 21),
                 $urandom_range(2000, 40000));
      test_random(7);
    end
    drain();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/qptp_pkg.sv
sv/quintic_ptp_trajectory.sv
sv/qptp_checker.sv
sim/tb_quintic_ptp_trajectory.sv
